// ===== src/tgi_pkg.sv =====
// Shared types and codes for the trilinear grid interpolator.
`default_nettype none
package tgi_pkg;

	localparam int SAMPLE_W = 16;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	// Item kinds.
	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

endpackage
`default_nettype wire

// ===== src/tgi_ram.sv =====
// Generic single-port RAM with registered read data.
`default_nettype none
module tgi_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8192
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ===== src/trilinear_grid_interpolator_core.sv =====
// Top level of the trilinear grid interpolator: grid RAM, sequencer and shared lerp unit.
//
// A write word stores sample_value at the integer parts of its coordinates: it is
// accepted, then written to the RAM in ST_WR. A query word streams the eight corner
// samples out of the single-port grid RAM in ST_RD (each pair along k is folded by the
// lerp unit as its second sample arrives), then ST_IL1, ST_IL2 and ST_JL run the two i
// steps and the final j step through the same unit; only then is the next word taken.
// The result sits in an output register; a new word is accepted while it waits, but the
// next result is held back until the previous one is taken. The grid holds no reset value:
// query only entries that have been written.
`default_nettype none
module trilinear_grid_interpolator_core
	import tgi_pkg::*;
#(
	parameter int GRID_I    = 32,
	parameter int GRID_J    = 32,
	parameter int GRID_K    = 8,
	parameter int FRAC_BITS = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        kind,
	input  wire logic [12:0] coord_i,
	input  wire logic [12:0] coord_j,
	input  wire logic [10:0] coord_k,
	input  wire sample_t     sample_value,
	output logic             out_valid,
	input  wire logic        out_stall,
	output sample_t          interp_value
);

	localparam int DEPTH = GRID_I * GRID_J * GRID_K;
	localparam int AW    = $clog2(DEPTH);
	localparam int IW    = $clog2(GRID_I);
	localparam int JW    = $clog2(GRID_J);
	localparam int KW    = $clog2(GRID_K);
	localparam int PW    = SAMPLE_W + 2 + FRAC_BITS;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WR,
		ST_RD,
		ST_IL1,
		ST_IL2,
		ST_JL
	} state_t;

	state_t state_q;
	logic [3:0] n_q;
	logic out_valid_q;
	sample_t interp_q;

	logic [IW-1:0] ilo_q, ihi_q;
	logic [JW-1:0] jlo_q, jhi_q;
	logic [KW-1:0] klo_q, khi_q;
	logic [FRAC_BITS-1:0] fi_q, fj_q, fk_q;
	sample_t sample_q;
	sample_t a_q;
	sample_t c_q [4];

	logic in_acc;
	logic [2:0] corner;
	logic [2:0] m;
	logic [IW-1:0] i_sel;
	logic [JW-1:0] j_sel;
	logic [KW-1:0] k_sel;
	logic [AW-1:0] ram_addr;
	logic ram_we;
	sample_t ram_rdata;

	sample_t lerp_a, lerp_b, lerp_res;
	logic [FRAC_BITS-1:0] lerp_f;
	logic signed [SAMPLE_W:0] diff;
	logic signed [PW-1:0] diff_x, f_x, prod, rnd, shd;

	function automatic logic [7:0] axis_lo(input logic [15:0] coord, input logic [7:0] top);
		logic [15:0] whole;
		whole = coord >> FRAC_BITS;
		if (whole >= 16'(top)) begin
			axis_lo = top;
		end else begin
			axis_lo = whole[7:0];
		end
	endfunction

	function automatic logic [7:0] axis_hi(input logic [15:0] coord, input logic [7:0] top);
		logic [15:0] whole;
		whole = coord >> FRAC_BITS;
		if (whole >= 16'(top)) begin
			axis_hi = top;
		end else begin
			axis_hi = 8'(whole + 16'd1);
		end
	endfunction

	// Past the grid the fraction drops to zero.
	function automatic logic [FRAC_BITS-1:0] axis_frac(input logic [15:0] coord,
			input logic [7:0] top);
		logic [15:0] whole;
		whole = coord >> FRAC_BITS;
		if (whole > 16'(top)) begin
			axis_frac = '0;
		end else begin
			axis_frac = FRAC_BITS'(32'(coord));
		end
	endfunction

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;

	// Corner code: bit 0 selects k, bit 1 selects j, bit 2 selects i.
	assign corner = (state_q == ST_RD) ? n_q[2:0] : 3'd0;
	assign m      = 3'(n_q - 4'd1);

	always_comb begin
		k_sel = corner[0] ? khi_q : klo_q;
		j_sel = corner[1] ? jhi_q : jlo_q;
		i_sel = corner[2] ? ihi_q : ilo_q;
	end

	assign ram_addr = AW'(32'(k_sel) * (GRID_I * GRID_J) + 32'(i_sel) * GRID_J + 32'(j_sel));
	assign ram_we   = (state_q == ST_WR);

	tgi_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(DEPTH)
	) u_grid (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(sample_q),
		.rdata(ram_rdata)
	);

	// Shared lerp unit: a + round((b - a) * f / 2^FRAC_BITS), ties upward.
	always_comb begin
		case (state_q)
			ST_IL1: begin
				lerp_a = c_q[0];
				lerp_b = c_q[2];
				lerp_f = fi_q;
			end
			ST_IL2: begin
				lerp_a = c_q[1];
				lerp_b = c_q[3];
				lerp_f = fi_q;
			end
			ST_JL: begin
				lerp_a = c_q[0];
				lerp_b = c_q[1];
				lerp_f = fj_q;
			end
			default: begin
				lerp_a = a_q;
				lerp_b = ram_rdata;
				lerp_f = fk_q;
			end
		endcase
	end

	always_comb begin
		diff     = (SAMPLE_W + 1)'(lerp_b) - (SAMPLE_W + 1)'(lerp_a);
		diff_x   = PW'(diff);
		f_x      = $signed(PW'(lerp_f));
		prod     = diff_x * f_x;
		rnd      = prod + (PW'(1) <<< (FRAC_BITS - 1));
		shd      = rnd >>> FRAC_BITS;
		lerp_res = lerp_a + SAMPLE_W'(shd);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			n_q         <= '0;
			out_valid_q <= 1'b0;
			interp_q    <= '0;
		end else begin
			// The final step refills the output register itself.
			if (out_valid_q && !out_stall && state_q != ST_JL) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					n_q <= '0;
					if (in_acc) begin
						state_q <= (kind == KIND_WRITE) ? ST_WR : ST_RD;
					end
				end
				ST_WR: begin
					state_q <= ST_IDLE;
				end
				ST_RD: begin
					n_q <= n_q + 4'd1;
					if (n_q == 4'd8) begin
						state_q <= ST_IL1;
					end
				end
				ST_IL1: begin
					state_q <= ST_IL2;
				end
				ST_IL2: begin
					state_q <= ST_JL;
				end
				ST_JL: begin
					// Hold the result until the previous word has gone.
					if (!out_valid_q || !out_stall) begin
						interp_q    <= lerp_res;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			ilo_q    <= IW'(axis_lo(16'(coord_i), 8'(GRID_I - 1)));
			ihi_q    <= IW'(axis_hi(16'(coord_i), 8'(GRID_I - 1)));
			fi_q     <= axis_frac(16'(coord_i), 8'(GRID_I - 1));
			jlo_q    <= JW'(axis_lo(16'(coord_j), 8'(GRID_J - 1)));
			jhi_q    <= JW'(axis_hi(16'(coord_j), 8'(GRID_J - 1)));
			fj_q     <= axis_frac(16'(coord_j), 8'(GRID_J - 1));
			klo_q    <= KW'(axis_lo(16'(coord_k), 8'(GRID_K - 1)));
			khi_q    <= KW'(axis_hi(16'(coord_k), 8'(GRID_K - 1)));
			fk_q     <= axis_frac(16'(coord_k), 8'(GRID_K - 1));
			sample_q <= sample_value;
		end
		if (state_q == ST_RD && n_q != 4'd0) begin
			// Low-k sample waits for its high-k partner, then fold along k.
			if (!m[0]) begin
				a_q <= ram_rdata;
			end else begin
				c_q[m[2:1]] <= lerp_res;
			end
		end
		if (state_q == ST_IL1) begin
			c_q[0] <= lerp_res;
		end
		if (state_q == ST_IL2) begin
			c_q[1] <= lerp_res;
		end
	end

	assign out_valid    = out_valid_q;
	assign interp_value = interp_q;

endmodule
`default_nettype wire

// ===== src/tgi_checker.sv =====
// Port-level checker for the trilinear grid interpolator, with its bind.
`default_nettype none
module tgi_checker
	import tgi_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        kind,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire sample_t     interp_value
);

	logic in_acc;
	assign in_acc = in_valid && !in_stall;

	// Stalled result word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(interp_value))
		else $error("result word changed or dropped while stalled");

	// An accepted word keeps the block busy for the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> in_stall)
		else $error("input taken again straight after a word");

	// A write word accepted while no result waits produces no result.
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && kind == KIND_WRITE && !out_valid |=> !out_valid ##1 !out_valid)
		else $error("result appeared after a write word");

	// A result only appears at the end of a query, while the input side was busy.
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without a query in flight");

endmodule

bind trilinear_grid_interpolator_core tgi_checker u_tgi_checker (.*);
`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking testbench for trilinear_grid_interpolator_core: grid writes, queries and handshakes.
`timescale 1ns / 1ps

module testbench;
	import tgi_pkg::*;

	localparam int GRID_I      = 32;
	localparam int GRID_J      = 32;
	localparam int GRID_K      = 8;
	localparam int FRAC_BITS   = 8;
	localparam int FRAC_ONE    = 1 << FRAC_BITS;
	localparam int GRID_CELLS  = GRID_I * GRID_J * GRID_K;
	localparam int TOTAL_WORDS = 1500;
	localparam int SETTLE      = 40;
	localparam int CYCLE_LIMIT = 500000;

	typedef struct {
		logic        kind;
		logic [12:0] ci;
		logic [12:0] cj;
		logic [10:0] ck;
		sample_t     sv;
	} grid_word_t;

	// Grid image and queue of interpolated values still owed by the block.
	class interp_scoreboard;
		sample_t grid [GRID_CELLS];
		bit      written [GRID_CELLS];
		sample_t expected_q [$];
		int      errors;
		int      checked;
		int      queries;
		int      cells_written;

		function void split_axis(int coord, int size, output int lo, output int hi,
				output int frac);
			int whole;
			whole = coord >> FRAC_BITS;
			if (whole >= size - 1) begin
				lo   = size - 1;
				hi   = size - 1;
				frac = (whole == size - 1) ? (coord & (FRAC_ONE - 1)) : 0;
			end else begin
				lo   = whole;
				hi   = whole + 1;
				frac = coord & (FRAC_ONE - 1);
			end
		endfunction

		function int cell_index(int k, int i, int j);
			return (k * GRID_I + i) * GRID_J + j;
		endfunction

		// Round to nearest, ties upward: arithmetic shift floors.
		function int lerp_step(int a, int b, int f);
			return (a * (FRAC_ONE - f) + b * f + FRAC_ONE / 2) >>> FRAC_BITS;
		endfunction

		function int corner(int k, int i, int j);
			return int'(grid[cell_index(k, i, j)]);
		endfunction

		function void note_input(grid_word_t w);
			int klo, khi, fk, ilo, ihi, fi, jlo, jhi, fj;
			int c11, c12, c21, c22, r1, r2;
			split_axis(int'(w.ck), GRID_K, klo, khi, fk);
			split_axis(int'(w.ci), GRID_I, ilo, ihi, fi);
			split_axis(int'(w.cj), GRID_J, jlo, jhi, fj);
			if (w.kind == KIND_WRITE) begin
				if (!written[cell_index(klo, ilo, jlo)])
					cells_written++;
				grid[cell_index(klo, ilo, jlo)]    = w.sv;
				written[cell_index(klo, ilo, jlo)] = 1'b1;
			end else begin
				c11 = lerp_step(corner(klo, ilo, jlo), corner(khi, ilo, jlo), fk);
				c12 = lerp_step(corner(klo, ilo, jhi), corner(khi, ilo, jhi), fk);
				c21 = lerp_step(corner(klo, ihi, jlo), corner(khi, ihi, jlo), fk);
				c22 = lerp_step(corner(klo, ihi, jhi), corner(khi, ihi, jhi), fk);
				r1  = lerp_step(c11, c21, fi);
				r2  = lerp_step(c12, c22, fi);
				expected_q.push_back(sample_t'(lerp_step(r1, r2, fj)));
				queries++;
			end
		endfunction

		function void check_result(sample_t got);
			sample_t want;
			if (expected_q.size() == 0) begin
				$error("interp_value %0d arrived with no query outstanding", got);
				errors++;
			end else begin
				want = expected_q.pop_front();
				checked++;
				if (got !== want) begin
					$error("interp_value mismatch: expected %0d, got %0d", want, got);
					errors++;
				end
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        kind;
	logic [12:0] coord_i;
	logic [12:0] coord_j;
	logic [10:0] coord_k;
	sample_t     sample_value;
	logic        out_valid;
	logic        out_stall;
	sample_t     interp_value;

	interp_scoreboard sb = new();
	bit sender_burst;
	bit taker_burst;
	int words_sent;
	int cycle_count;

	trilinear_grid_interpolator_core #(
		.GRID_I   (GRID_I),
		.GRID_J   (GRID_J),
		.GRID_K   (GRID_K),
		.FRAC_BITS(FRAC_BITS)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.kind        (kind),
		.coord_i     (coord_i),
		.coord_j     (coord_j),
		.coord_k     (coord_k),
		.sample_value(sample_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.interp_value(interp_value)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("trilinear_grid_interpolator_core regression: fail");
		$finish;
	end

	// Result side: take a word, then hold stall for a drawn number of cycles.
	initial begin
		int hold;
		hold      = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_stall == 1'b0) begin
				sb.check_result(interp_value);
				hold = taker_burst ? 0 : $urandom_range(0, 9);
				if ($urandom_range(0, 39) == 0)
					taker_burst = !taker_burst;
			end
			if (hold > 0) begin
				out_stall <= 1'b1;
				hold--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	function automatic sample_t draw_sample();
		case ($urandom_range(0, 7))
			0: return sample_t'(16'sh8000);
			1: return sample_t'(16'sh7fff);
			default: return sample_t'($urandom);
		endcase
	endfunction

	function automatic int draw_frac();
		return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, FRAC_ONE - 1);
	endfunction

	// Mostly the two corner windows of the plane, so queries reuse written cells.
	function automatic logic [12:0] draw_plane_coord();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return 13'(($urandom_range(0, 3) << FRAC_BITS) | draw_frac());
		if (r < 7)
			return 13'(($urandom_range(GRID_I - 4, GRID_I - 1) << FRAC_BITS) | draw_frac());
		return 13'($urandom_range(0, 8191));
	endfunction

	task automatic send_word(grid_word_t w);
		int gap;
		gap = sender_burst ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		kind         <= w.kind;
		coord_i      <= w.ci;
		coord_j      <= w.cj;
		coord_k      <= w.ck;
		sample_value <= w.sv;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_input(w);
		words_sent++;
	endtask

	task automatic write_grid(int k, int i, int j, sample_t v);
		grid_word_t w;
		w.kind = KIND_WRITE;
		w.ci   = 13'((i << FRAC_BITS) | $urandom_range(0, FRAC_ONE - 1));
		w.cj   = 13'((j << FRAC_BITS) | $urandom_range(0, FRAC_ONE - 1));
		w.ck   = 11'((k << FRAC_BITS) | $urandom_range(0, FRAC_ONE - 1));
		w.sv   = v;
		send_word(w);
	endtask

	// Fill any unwritten corner first, then issue the query itself.
	task automatic query_at(logic [12:0] ci, logic [12:0] cj, logic [10:0] ck);
		int klo, khi, fk, ilo, ihi, fi, jlo, jhi, fj;
		grid_word_t w;
		sb.split_axis(int'(ck), GRID_K, klo, khi, fk);
		sb.split_axis(int'(ci), GRID_I, ilo, ihi, fi);
		sb.split_axis(int'(cj), GRID_J, jlo, jhi, fj);
		for (int a = 0; a < 2; a++)
			for (int b = 0; b < 2; b++)
				for (int c = 0; c < 2; c++)
					if (!sb.written[sb.cell_index(a ? khi : klo, b ? ihi : ilo,
							c ? jhi : jlo)])
						write_grid(a ? khi : klo, b ? ihi : ilo, c ? jhi : jlo,
							draw_sample());
		w.kind = KIND_QUERY;
		w.ci   = ci;
		w.cj   = cj;
		w.ck   = ck;
		w.sv   = sample_t'($urandom);
		send_word(w);
	endtask

	// Hold the sender until every owed result has been taken.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	initial begin
		grid_word_t w;
		bit paused;
		in_valid     = 1'b0;
		kind         = KIND_WRITE;
		coord_i      = '0;
		coord_j      = '0;
		coord_k      = '0;
		sample_value = '0;
		arst_n       = 1'b0;
		words_sent   = 0;
		paused       = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Origin cube with alternating extremes: integral, tie, largest and smallest fraction.
		for (int k = 0; k < 2; k++)
			for (int i = 0; i < 2; i++)
				for (int j = 0; j < 2; j++)
					write_grid(k, i, j, ((k ^ i ^ j) & 1) ? sample_t'(16'sh7fff)
						: sample_t'(16'sh8000));
		query_at(13'd0, 13'd0, 11'd0);
		query_at(13'd128, 13'd128, 11'd128);
		query_at(13'd255, 13'd255, 11'd255);
		query_at(13'd1, 13'd1, 11'd1);
		// Top edge with nonzero fractions, then integral at the top of i and k.
		query_at(13'h1fff, 13'h1fff, 11'h7ff);
		query_at(13'((GRID_I - 1) << FRAC_BITS), 13'd0, 11'((GRID_K - 1) << FRAC_BITS));
		drain_results();

		while (words_sent < TOTAL_WORDS) begin
			if ($urandom_range(0, 39) == 0)
				sender_burst = !sender_burst;
			if (!paused && words_sent >= TOTAL_WORDS / 2) begin
				paused = 1'b1;
				drain_results();
			end
			if ($urandom_range(0, 99) < 15) begin
				w.kind = KIND_WRITE;
				w.ci   = 13'($urandom_range(0, 8191));
				w.cj   = 13'($urandom_range(0, 8191));
				w.ck   = 11'($urandom_range(0, 2047));
				w.sv   = draw_sample();
				send_word(w);
			end else begin
				query_at(draw_plane_coord(), draw_plane_coord(),
					11'(($urandom_range(0, GRID_K - 1) << FRAC_BITS) | draw_frac()));
			end
		end
		drain_results();

		$display("Sent %0d words including %0d queries; %0d results compared.",
			words_sent, sb.queries, sb.checked);
		$display("Grid cells written: %0d of %0d.", sb.cells_written, GRID_CELLS);
		if (sb.errors == 0 && sb.expected_q.size() == 0) begin
			$display("trilinear_grid_interpolator_core regression: pass");
		end else begin
			$display("trilinear_grid_interpolator_core regression: fail");
		end
		$finish;
	end

endmodule

// ===== trilinear_grid_interpolator_core.f =====
src/tgi_pkg.sv
src/tgi_ram.sv
src/trilinear_grid_interpolator_core.sv
src/tgi_checker.sv
bench/testbench.sv
